// ----- hdl/hufd_pkg.sv -----
`timescale 1ns / 1ps

package hufd_pkg;

  localparam int IDX_W            = 9;
  localparam int SYM_W            = 8;
  localparam int CODE_W           = 8;
  localparam int NBITS_W          = 4;
  localparam int NODE_COUNT_DEF   = 512;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [NBITS_W-1:0] MAX_BITS = NBITS_W'(CODE_W);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx;
    node_t              node;
    logic [CODE_W-1:0]  code;
    logic [NBITS_W-1:0] nbits;
    logic               restart;
  } req_t;

endpackage

// ----- hdl/hufd_queue.sv -----
`timescale 1ns / 1ps

module hufd_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hufd_pkg::req_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output hufd_pkg::req_t data_o,
  output logic          empty_o
);
  import hufd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/hufd_front.sv -----
`timescale 1ns / 1ps

module hufd_front #(
  parameter int SYMBOL_COUNT = hufd_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [hufd_pkg::IDX_W-1:0]    node_index_i,
  input  logic                          node_is_leaf_i,
  input  logic [hufd_pkg::SYM_W-1:0]    node_symbol_i,
  input  logic [hufd_pkg::IDX_W-1:0]    left_index_i,
  input  logic [hufd_pkg::IDX_W-1:0]    right_index_i,
  input  logic [hufd_pkg::CODE_W-1:0]   code_byte_i,
  input  logic [hufd_pkg::NBITS_W-1:0]  valid_bits_i,
  input  logic                          restart_i,
  input  logic                          full_i,
  output logic                          push_o,
  output hufd_pkg::req_t                req_o
);
  import hufd_pkg::*;

  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [SYM_W-1:0] SYM_TOP = SYM_W'(SYMBOL_COUNT - 1);

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    req_o             = '0;
    req_o.op          = op_e'(operation_i);
    req_o.idx         = node_index_i;
    req_o.node.leaf   = node_is_leaf_i;
    // symbols past the alphabet collapse onto its last code
    req_o.node.symbol = ({1'b0, node_symbol_i} >= SYM_LIMIT) ? SYM_TOP : node_symbol_i;
    req_o.node.left   = left_index_i;
    req_o.node.right  = right_index_i;
    req_o.code        = code_byte_i;
    req_o.nbits       = (valid_bits_i > MAX_BITS) ? MAX_BITS : valid_bits_i;
    req_o.restart     = restart_i;
  end

endmodule

// ----- hdl/hufd_back.sv -----
`timescale 1ns / 1ps

module hufd_back #(
  parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  hufd_pkg::req_t              req_i,
  output logic                        pop_o,
  input  logic                        cfg_valid_i,
  input  logic [hufd_pkg::IDX_W-1:0]  cfg_data_i,
  output logic [hufd_pkg::SYM_W-1:0]  symbol_o,
  output logic                        last_o,
  output logic                        strobe_o
);
  import hufd_pkg::*;

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam logic [IDX_W:0] NODE_LIMIT = (IDX_W + 1)'(NODE_COUNT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CUR   = 2'd1;
  localparam logic [1:0] S_CHILD = 2'd2;
  localparam logic [1:0] S_END   = 2'd3;

  node_t node_mem [NODE_COUNT];

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [IDX_W-1:0]   root_q;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [NBITS_W-1:0] cnt_q, cnt_d;
  logic [SYM_W-1:0]   pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic               last_q, last_d;
  logic               strobe_q, strobe_d;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  logic               wr_en;
  node_t              rdata_q;
  logic               rd_oob_q;
  node_t              entry;
  logic [IDX_W-1:0]   child;

  // indices past the table read as an internal node pointing at entry zero
  assign entry = rd_oob_q ? '0 : rdata_q;
  assign child = code_q[CODE_W-1] ? entry.right : entry.left;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    code_d     = code_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    sym_d      = sym_q;
    last_d     = 1'b0;
    strobe_d   = 1'b0;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = pos_q;
    wr_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (req_i.op == OP_WRITE) begin
            wr_en = ({1'b0, req_i.idx} < NODE_LIMIT);
          end else begin
            pos_d   = req_i.restart ? root_q : pos_q;
            rd_en   = 1'b1;
            rd_idx  = pos_d;
            code_d  = req_i.code;
            cnt_d   = req_i.nbits;
            state_d = S_CUR;
          end
        end
      end
      S_CUR: begin
        // entry holds the node at the walk position
        if (cnt_q == '0) begin
          state_d = S_END;
        end else begin
          rd_en   = 1'b1;
          rd_idx  = child;
          pos_d   = child;
          state_d = S_CHILD;
        end
      end
      S_CHILD: begin
        // entry holds the node just reached
        code_d = code_q << 1;
        cnt_d  = cnt_q - NBITS_W'(1);
        if (entry.leaf) begin
          if (pend_vld_q) begin
            strobe_d = 1'b1;
            sym_d    = pend_q;
          end
          pend_d     = entry.symbol;
          pend_vld_d = 1'b1;
          pos_d      = root_q;
          rd_en      = 1'b1;
          rd_idx     = root_q;
          state_d    = S_CUR;
        end else if (cnt_d != '0) begin
          rd_en  = 1'b1;
          rd_idx = code_q[CODE_W-2] ? entry.right : entry.left;
          pos_d  = rd_idx;
        end else begin
          state_d = S_END;
        end
      end
      S_END: begin
        if (pend_vld_q) begin
          strobe_d = 1'b1;
          sym_d    = pend_q;
          last_d   = 1'b1;
        end
        pend_vld_d = 1'b0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      root_q     <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
      if (cfg_valid_i) begin
        root_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    cnt_q  <= cnt_d;
    pend_q <= pend_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[req_i.idx[ADDR_W-1:0]] <= req_i.node;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= node_mem[rd_idx[ADDR_W-1:0]];
      rd_oob_q <= ({1'b0, rd_idx} >= NODE_LIMIT);
    end
  end

  assign symbol_o = sym_q;
  assign last_o   = last_q;
  assign strobe_o = strobe_q;

endmodule

// ----- hdl/huffman_tree_walk_decoder.sv -----
// Huffman decoder walking a code tree held in a single-port node table. A request
// with operation 0 writes one node entry; a request with operation 1 decodes one
// code byte, msb first, and every step of the walk is one read of the node table
// and each leaf costs one more read to fetch the root.
// Requests go through a two-entry queue, so start is taken whenever busy_o is
// low; busy_o is high only while that queue is full. Decoded symbols leave as
// single-cycle pulses on result_strobe_o with symbol_o and last_of_byte_o; the
// receiver cannot stall them and must take each one in the cycle it appears.
// The user must write the root index via the cfg channel (always ready) only while
// the block is idle (not enforced); it takes effect at the next leaf or restart.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT   = hufd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT = hufd_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [hufd_pkg::IDX_W-1:0]    node_index_i,
  input  logic                          node_is_leaf_i,
  input  logic [hufd_pkg::SYM_W-1:0]    node_symbol_i,
  input  logic [hufd_pkg::IDX_W-1:0]    left_index_i,
  input  logic [hufd_pkg::IDX_W-1:0]    right_index_i,
  input  logic [hufd_pkg::CODE_W-1:0]   code_byte_i,
  input  logic [hufd_pkg::NBITS_W-1:0]  valid_bits_i,
  input  logic                          restart_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hufd_pkg::IDX_W-1:0]    cfg_data_i,
  output logic [hufd_pkg::SYM_W-1:0]    symbol_o,
  output logic                          last_of_byte_o,
  output logic                          result_strobe_o
);
  import hufd_pkg::*;

  logic full;
  logic push;
  logic pop;
  logic empty;
  req_t req_in;
  req_t req_out;

  assign cfg_ready_o = 1'b1;

  hufd_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .node_index_i  (node_index_i),
    .node_is_leaf_i(node_is_leaf_i),
    .node_symbol_i (node_symbol_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .code_byte_i   (code_byte_i),
    .valid_bits_i  (valid_bits_i),
    .restart_i     (restart_i),
    .full_i        (full),
    .push_o        (push),
    .req_o         (req_in)
  );

  hufd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (req_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (req_out),
    .empty_o(empty)
  );

  hufd_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .req_i      (req_out),
    .pop_o      (pop),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .symbol_o   (symbol_o),
    .last_o     (last_of_byte_o),
    .strobe_o   (result_strobe_o)
  );

endmodule

// ----- hdl/hufd_checker.sv -----
`timescale 1ns / 1ps

module hufd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_strobe_o
);

  // every symbol needs a root fetch, so results never come back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe on two consecutive cycles");

  // reset sampled low at an edge leaves the outputs quiet at the next edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> (!result_strobe_o && !busy_o))
    else $error("strobe or busy active during reset");

  // the queue only fills through an accepted request
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("busy rose without an accepted request");

endmodule

bind huffman_tree_walk_decoder hufd_checker u_hufd_checker (.*);
